/* rtl/aro_pkg.sv */
// Shared constants, state encoding and inter-module structs for the read overlap block.
package aro_pkg;

	localparam int MAX_READ_LEN = 128;
	localparam int LEN_W        = $clog2(MAX_READ_LEN + 1);
	localparam int IDX_W        = $clog2(MAX_READ_LEN);
	localparam int CHAR_W       = 8;
	localparam int MM_W         = 4;
	localparam int MINOV_W      = 8;
	localparam int OUT_W        = 8;
	localparam int CFG_DATA_W   = 8;
	localparam int CFG_IDX_W    = 1;
	localparam int SUM_W        = ((LEN_W > MINOV_W) ? LEN_W : MINOV_W) + 1;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_MM      = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_OVERLAP = 1'd1;

	localparam logic [MM_W-1:0]    MAX_MM_RESET      = 4'd2;
	localparam logic [MINOV_W-1:0] MIN_OVERLAP_RESET = 8'd13;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_INIT,
		ST_CMP,
		ST_SCAN,
		ST_WAIT
	} state_t;

	// Controls broadcast to every cell of the row.
	typedef struct packed {
		logic              init;
		logic              step;
		logic              scan;
		logic [MM_W-1:0]   max_mm;
		logic [CHAR_W-1:0] b_bc;
	} cell_ctrl_t;

	// What one cell hands to its lower neighbor.
	typedef struct packed {
		logic [CHAR_W-1:0] a;
		logic [CHAR_W-1:0] b;
		logic              win;
		logic              fail;
	} link_t;

endpackage

/* rtl/aro_cell.sv */
// One cell of the row: a character of each read, a compare window bit and a mismatch counter.
module aro_cell (
	input  logic                        clk,
	input  aro_pkg::cell_ctrl_t         ctrl,
	input  logic                        wr_a,
	input  logic                        wr_b,
	input  logic [aro_pkg::CHAR_W-1:0]  char_a,
	input  logic [aro_pkg::CHAR_W-1:0]  char_b,
	input  logic                        win_init,
	input  aro_pkg::link_t              nb,
	output aro_pkg::link_t              cur
);

	logic [aro_pkg::CHAR_W-1:0] a_q;
	logic [aro_pkg::CHAR_W-1:0] b_q;
	logic                       win_q;
	logic                       fail_q;
	logic [aro_pkg::MM_W-1:0]   cnt_q;

	always_ff @(posedge clk) begin
		if (wr_a) begin
			a_q <= char_a;
		end else if (ctrl.step) begin
			a_q <= nb.a;
		end
		if (wr_b) begin
			b_q <= char_b;
		end else if (ctrl.step) begin
			b_q <= nb.b;
		end
		if (ctrl.init) begin
			win_q  <= win_init;
			fail_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctrl.step) begin
			win_q <= nb.win;
			// count a mismatch; one past the limit marks this offset as failed
			if (win_q && !fail_q && (a_q != ctrl.b_bc)) begin
				if (cnt_q == ctrl.max_mm) begin
					fail_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + aro_pkg::MM_W'(1);
				end
			end
		end else if (ctrl.scan) begin
			fail_q <= nb.fail;
		end
	end

	assign cur.a    = a_q;
	assign cur.b    = b_q;
	assign cur.win  = win_q;
	assign cur.fail = fail_q;

endmodule

/* rtl/aro_chain.sv */
// Row of compare cells with write decode, window setup and the row's tail.
module aro_chain (
	input  logic                        clk,
	input  aro_pkg::cell_ctrl_t         ctrl,
	input  logic                        load_a,
	input  logic [aro_pkg::IDX_W-1:0]   idx_a,
	input  logic [aro_pkg::CHAR_W-1:0]  char_a,
	input  logic                        load_b,
	input  logic [aro_pkg::IDX_W-1:0]   idx_b,
	input  logic [aro_pkg::CHAR_W-1:0]  char_b,
	input  logic [aro_pkg::LEN_W-1:0]   len_a,
	output logic [aro_pkg::CHAR_W-1:0]  b_head,
	output logic                        fail_head
);

	aro_pkg::link_t links [aro_pkg::MAX_READ_LEN+1];

	// past the end of read A: nothing to compare, and offsets read as failed
	assign links[aro_pkg::MAX_READ_LEN] = '{a: '0, b: '0, win: 1'b0, fail: 1'b1};

	for (genvar k = 0; k < aro_pkg::MAX_READ_LEN; k++) begin : g_cell
		logic wr_a;
		logic wr_b;
		logic win_init;

		assign wr_a     = load_a && (idx_a == aro_pkg::IDX_W'(k));
		assign wr_b     = load_b && (idx_b == aro_pkg::IDX_W'(k));
		assign win_init = aro_pkg::LEN_W'(k) < len_a;

		aro_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.wr_a     (wr_a),
			.wr_b     (wr_b),
			.char_a   (char_a),
			.char_b   (char_b),
			.win_init (win_init),
			.nb       (links[k+1]),
			.cur      (links[k])
		);
	end

	assign b_head    = links[0].b;
	assign fail_head = links[0].fail;

endmodule

/* rtl/approximate_read_overlap.sv */
// Top level: input loading, overlap search sequencer, result register and config registers.
//
// Reads A and B arrive side by side on the input channel (in_valid/in_ready), at most one
// character of each per transfer, flagged by valid_a and valid_b. In the load state every
// transfer offered is taken. The transfer with last set appends its characters and starts
// the search; no input is taken until the result has moved into the output register.
// Search: a setup state, then a compare phase that runs over the shorter read, in which read A
// shifts down the row of cells past a broadcast character of read B, each cell counting the
// mismatches of one offset, and a state to close the compare. A scan then shifts the fail
// flags out of the row, one offset per cycle, followed by a wait state that hands the result
// over once the output register is free.
// The output channel (out_valid/out_ready) carries overlap_len and truncated, held in an
// output register until the transfer; while it waits the next pair may load, and a
// finished search holds until the register is free.
// Config writes (cfg_we, cfg_index, cfg_wdata) take effect at once and belong to idle time.
// Reset clears both lengths, the overflow flag and the output valid, and restores
// max_mismatches to 2 and min_overlap to 13.
module approximate_read_overlap (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [aro_pkg::CHAR_W-1:0]      char_a,
	input  logic                            valid_a,
	input  logic [aro_pkg::CHAR_W-1:0]      char_b,
	input  logic                            valid_b,
	input  logic                            last,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [aro_pkg::OUT_W-1:0]       overlap_len,
	output logic                            truncated,
	input  logic                            cfg_we,
	input  logic [aro_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [aro_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	aro_pkg::state_t state_q;
	aro_pkg::state_t state_nxt;

	logic [aro_pkg::LEN_W-1:0]   len_a_q;
	logic [aro_pkg::LEN_W-1:0]   len_b_q;
	logic                        ovf_q;
	logic [aro_pkg::LEN_W-1:0]   t_q;
	logic [aro_pkg::LEN_W-1:0]   k_q;
	logic [aro_pkg::LEN_W-1:0]   res_q;
	logic [aro_pkg::MM_W-1:0]    max_mm_q;
	logic [aro_pkg::MINOV_W-1:0] min_ov_q;
	logic                        out_valid_q;
	logic [aro_pkg::OUT_W-1:0]   overlap_len_q;
	logic                        truncated_q;

	logic                        in_xfer;
	logic                        full_a;
	logic                        full_b;
	logic                        app_a;
	logic                        app_b;
	logic [aro_pkg::LEN_W-1:0]   shorter;
	logic [aro_pkg::MINOV_W-1:0] lowest;
	logic                        cmp_run;
	logic [aro_pkg::SUM_W-1:0]   k_low_sum;
	logic [aro_pkg::SUM_W-1:0]   k_short_sum;
	logic [aro_pkg::SUM_W-1:0]   len_a_ext;
	logic                        scan_stop;
	logic                        scan_hit;
	logic                        done;
	logic                        release_res;
	logic                        out_free;
	logic [aro_pkg::CHAR_W-1:0]  b_head;
	logic                        fail_head;
	aro_pkg::cell_ctrl_t         ctrl;

	assign in_xfer  = in_valid && in_ready;
	assign full_a   = len_a_q == aro_pkg::LEN_W'(aro_pkg::MAX_READ_LEN);
	assign full_b   = len_b_q == aro_pkg::LEN_W'(aro_pkg::MAX_READ_LEN);
	assign app_a    = in_xfer && valid_a && !full_a;
	assign app_b    = in_xfer && valid_b && !full_b;
	assign shorter  = (len_a_q < len_b_q) ? len_a_q : len_b_q;
	assign lowest   = (min_ov_q == '0) ? aro_pkg::MINOV_W'(1) : min_ov_q;
	assign cmp_run  = t_q != shorter;
	assign out_free = !out_valid_q || out_ready;

	// offset k covers overlap length len_a - k
	assign len_a_ext   = aro_pkg::SUM_W'(len_a_q);
	assign k_low_sum   = aro_pkg::SUM_W'(k_q) + aro_pkg::SUM_W'(lowest);
	assign k_short_sum = aro_pkg::SUM_W'(k_q) + aro_pkg::SUM_W'(shorter);
	assign scan_stop   = k_low_sum > len_a_ext;
	assign scan_hit    = !scan_stop && (k_short_sum >= len_a_ext) && !fail_head;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			aro_pkg::ST_LOAD: begin
				if (in_xfer && last) begin
					state_nxt = aro_pkg::ST_INIT;
				end
			end
			aro_pkg::ST_INIT: begin
				state_nxt = aro_pkg::ST_CMP;
			end
			aro_pkg::ST_CMP: begin
				if (!cmp_run) begin
					state_nxt = aro_pkg::ST_SCAN;
				end
			end
			aro_pkg::ST_SCAN: begin
				if (scan_stop || scan_hit) begin
					state_nxt = aro_pkg::ST_WAIT;
				end
			end
			aro_pkg::ST_WAIT: begin
				if (out_free) begin
					state_nxt = aro_pkg::ST_LOAD;
				end
			end
			default: begin
				state_nxt = aro_pkg::ST_LOAD;
			end
		endcase
	end

	always_comb begin
		in_ready    = state_q == aro_pkg::ST_LOAD;
		ctrl.init   = state_q == aro_pkg::ST_INIT;
		ctrl.step   = (state_q == aro_pkg::ST_CMP) && cmp_run;
		done        = (state_q == aro_pkg::ST_SCAN) && (scan_stop || scan_hit);
		ctrl.scan   = (state_q == aro_pkg::ST_SCAN) && !(scan_stop || scan_hit);
		release_res = (state_q == aro_pkg::ST_WAIT) && out_free;
		ctrl.max_mm = max_mm_q;
		ctrl.b_bc   = b_head;
	end

	aro_chain u_chain (
		.clk       (clk),
		.ctrl      (ctrl),
		.load_a    (app_a),
		.idx_a     (len_a_q[aro_pkg::IDX_W-1:0]),
		.char_a    (char_a),
		.load_b    (app_b),
		.idx_b     (len_b_q[aro_pkg::IDX_W-1:0]),
		.char_b    (char_b),
		.len_a     (len_a_q),
		.b_head    (b_head),
		.fail_head (fail_head)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= aro_pkg::ST_LOAD;
			len_a_q     <= '0;
			len_b_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
			max_mm_q    <= aro_pkg::MAX_MM_RESET;
			min_ov_q    <= aro_pkg::MIN_OVERLAP_RESET;
		end else begin
			state_q <= state_nxt;
			if (release_res) begin
				len_a_q <= '0;
				len_b_q <= '0;
				ovf_q   <= 1'b0;
			end else begin
				if (app_a) begin
					len_a_q <= len_a_q + aro_pkg::LEN_W'(1);
				end
				if (app_b) begin
					len_b_q <= len_b_q + aro_pkg::LEN_W'(1);
				end
				// drop characters past the buffer and remember it
				if (in_xfer && ((valid_a && full_a) || (valid_b && full_b))) begin
					ovf_q <= 1'b1;
				end
			end
			if (release_res) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					aro_pkg::REG_MAX_MM: begin
						max_mm_q <= cfg_wdata[aro_pkg::MM_W-1:0];
					end
					aro_pkg::REG_MIN_OVERLAP: begin
						min_ov_q <= cfg_wdata[aro_pkg::MINOV_W-1:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.init) begin
			t_q <= '0;
		end else if (ctrl.step) begin
			t_q <= t_q + aro_pkg::LEN_W'(1);
		end
		if (ctrl.init) begin
			k_q <= '0;
		end else if (ctrl.scan) begin
			k_q <= k_q + aro_pkg::LEN_W'(1);
		end
		if (done) begin
			res_q <= scan_hit ? (len_a_q - k_q) : '0;
		end
		if (release_res) begin
			overlap_len_q <= aro_pkg::OUT_W'(res_q);
			truncated_q   <= ovf_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign overlap_len = overlap_len_q;
	assign truncated   = truncated_q;

`ifndef SYNTH
	a_last_starts_search: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && last) |=> (state_q == aro_pkg::ST_INIT))
		else $error("last transfer did not start the search");

	a_cmp_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == aro_pkg::ST_CMP) |-> (t_q <= shorter))
		else $error("compare step count ran past the shorter read");

	a_scan_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == aro_pkg::ST_SCAN) |-> (k_q <= len_a_q))
		else $error("scan offset ran past read A");

	a_result_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == aro_pkg::ST_WAIT) |-> (res_q <= shorter))
		else $error("overlap longer than the shorter read");

	a_len_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(len_a_q <= aro_pkg::LEN_W'(aro_pkg::MAX_READ_LEN)) &&
		(len_b_q <= aro_pkg::LEN_W'(aro_pkg::MAX_READ_LEN)))
		else $error("read length beyond buffer size");
`endif

endmodule
